FILE: sv/dmtg_pkg.sv
// Shared codes, constants and the stage type of the multi-wave tone generator.
package dmtg_pkg;

   // Wave selector codes
   localparam logic [2:0] WAVE_SILENCE  = 3'd0;
   localparam logic [2:0] WAVE_SINE     = 3'd1;
   localparam logic [2:0] WAVE_SQUARE   = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_SAWTOOTH = 3'd4;
   localparam logic [2:0] WAVE_NOISE    = 3'd5;
   localparam logic [2:0] WAVE_DTMF     = 3'd6;

   // Sample format codes
   localparam logic [1:0] FMT_U8  = 2'd0;
   localparam logic [1:0] FMT_S16 = 2'd1;
   localparam logic [1:0] FMT_S24 = 2'd2;
   localparam logic [1:0] FMT_S32 = 2'd3;

   // Register indexes of the control port
   localparam logic [2:0] REG_WAVE_TYPE     = 3'd0;
   localparam logic [2:0] REG_TONE_STEP     = 3'd1;
   localparam logic [2:0] REG_PHASE_OFFSET  = 3'd2;
   localparam logic [2:0] REG_AMPLITUDE     = 3'd3;
   localparam logic [2:0] REG_DTMF_COL_STEP = 3'd4;
   localparam logic [2:0] REG_DTMF_ROW_STEP = 3'd5;
   localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd6;

   // Arithmetic constants
   localparam logic [31:0] PI_Q29    = 32'd1686629713;
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [15:0] AMP_FULL  = 16'd32768;
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'd1;

   // Payload of the first stage, beside the table reads
   typedef struct packed {
      logic [2:0]         wave;
      logic               neg_a;
      logic               neg_b;
      logic signed [32:0] w_direct;
   } front_type;

endpackage

FILE: sv/dmtg_sine_rom.sv
// Quarter-wave sine table in Q30 with two registered read ports.
module dmtg_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     read_en,
   input  logic [SINE_TABLE_BITS:0] addr_a,
   input  logic [SINE_TABLE_BITS:0] addr_b,
   output logic [30:0]              data_a,
   output logic [30:0]              data_b
);
   import dmtg_pkg::*;

   localparam int TABLE_N = 1 << SINE_TABLE_BITS;

   typedef logic [30:0] rom_type [0:TABLE_N];

   // Taylor series of odd terms through x^17, truncating at each step
   function automatic rom_type build_rom();
      rom_type     tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      sum;
      for (int i = 0; i <= TABLE_N; i++) begin
         x   = (64'(PI_Q29) * 64'(i) + 64'(TABLE_N / 2)) >> SINE_TABLE_BITS;
         x2  = (x * x) >> 30;
         t   = x;
         sum = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
         end
         tab[i] = 31'(sum);
      end
      tab[0]       = '0;
      tab[TABLE_N] = Q30_ONE;
      return tab;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [30:0] data_a_ff;
   logic [30:0] data_b_ff;

   // Read both ports; hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (read_en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

FILE: sv/dmtg_front.sv
// Phase accumulators, noise LFSR, table addressing and direct waves.
module dmtg_front #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  logic                     accept,
   input  logic                     restart_phase,
   input  logic [2:0]               wave_type,
   input  logic [31:0]              tone_step,
   input  logic [31:0]              phase_offset,
   input  logic [31:0]              dtmf_col_step,
   input  logic [31:0]              dtmf_row_step,
   output logic [SINE_TABLE_BITS:0] addr_a,
   output logic [SINE_TABLE_BITS:0] addr_b,
   output dmtg_pkg::front_type      front_q
);
   import dmtg_pkg::*;

   localparam int SHIFT_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int SHIFT_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
   localparam logic [SINE_TABLE_BITS:0] TABLE_N = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);

   // Align a 32-bit cycle fraction to the accumulator width
   function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] v);
      logic [63:0] w;
      w = 64'(v);
      w = (w << SHIFT_UP) >> SHIFT_DN;
      return w[PHASE_BITS-1:0];
   endfunction

   // Align an accumulator value to a 32-bit cycle fraction
   function automatic logic [31:0] to_frac(input logic [PHASE_BITS-1:0] p);
      logic [63:0] w;
      w = 64'(p);
      w = (w >> SHIFT_UP) << SHIFT_DN;
      return w[31:0];
   endfunction

   // Table index of a sine of a 32-bit angle (the sign is bit 31 of the angle)
   function automatic logic [SINE_TABLE_BITS:0] table_addr(input logic [31:0] ang);
      logic [SINE_TABLE_BITS:0] k;
      k = {1'b0, ang[29 -: SINE_TABLE_BITS]};
      return ang[30] ? TABLE_N - k : k;
   endfunction

   logic [PHASE_BITS-1:0] tone_ff;
   logic [PHASE_BITS-1:0] col_ff;
   logic [PHASE_BITS-1:0] row_ff;
   logic [31:0]           lfsr_ff;
   front_type             front_ff;

   logic [PHASE_BITS-1:0] tone_base;
   logic [PHASE_BITS-1:0] col_base;
   logic [PHASE_BITS-1:0] row_base;
   logic [PHASE_BITS-1:0] tone_in;
   logic [PHASE_BITS-1:0] col_in;
   logic [PHASE_BITS-1:0] row_in;
   logic [31:0]           lfsr_in;
   logic [31:0]           u;
   logic [31:0]           ang_a;
   logic [31:0]           ang_b;
   logic signed [34:0]    tri_w;
   front_type             front_in;

   // Clear the accumulators ahead of this sample on restart
   always_comb begin
      tone_base = restart_phase ? '0 : tone_ff;
      col_base  = restart_phase ? '0 : col_ff;
      row_base  = restart_phase ? '0 : row_ff;
      tone_in   = tone_base + to_phase(tone_step);
      col_in    = (wave_type == WAVE_DTMF) ? col_base + to_phase(dtmf_col_step) : col_base;
      row_in    = (wave_type == WAVE_DTMF) ? row_base + to_phase(dtmf_row_step) : row_base;
      lfsr_in   = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 32'd0);
   end

   // Table angles: port A serves the sine or the column tone, port B the row tone
   always_comb begin
      u      = to_frac(tone_base);
      ang_a  = (wave_type == WAVE_SINE) ? to_frac(tone_base + to_phase(phase_offset))
                                        : to_frac(col_base);
      ang_b  = to_frac(row_base);
      addr_a = table_addr(ang_a);
      addr_b = table_addr(ang_b);
   end

   // Waves that need no table
   always_comb begin
      if (u <= 32'h8000_0000) begin
         tri_w = $signed({2'b00, u, 1'b0}) - 35'sd2147483648;
      end else begin
         tri_w = 35'sd6442450944 - $signed({2'b00, u, 1'b0});
      end
      front_in.wave  = wave_type;
      front_in.neg_a = ang_a[31];
      front_in.neg_b = ang_b[31];
      case (wave_type)
         WAVE_SQUARE:   front_in.w_direct = u[31] ? -33'sd2147483648 : 33'sd2147483648;
         WAVE_TRIANGLE: front_in.w_direct = tri_w[32:0];
         WAVE_SAWTOOTH: front_in.w_direct = $signed({1'b0, u}) - 33'sd2147483648;
         WAVE_NOISE:    front_in.w_direct = $signed({2'b00, lfsr_in[31:1]});
         default:       front_in.w_direct = '0;
      endcase
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         lfsr_ff <= LFSR_SEED;
      end else if (accept) begin
         tone_ff <= tone_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         if (wave_type == WAVE_NOISE) begin
            lfsr_ff <= lfsr_in;
         end
      end
   end

   // Stage register beside the table read
   always_ff @(posedge clock) begin
      if (load_en) begin
         front_ff <= front_in;
      end
   end

   assign front_q = front_ff;

endmodule

FILE: sv/dmtg_scale.sv
// Wave assembly, amplitude multiply, rounding and saturation to the format.
module dmtg_scale (
   input  logic                clock,
   input  logic                mul_en,
   input  logic                out_en,
   input  dmtg_pkg::front_type front_q,
   input  logic [30:0]         rom_a,
   input  logic [30:0]         rom_b,
   input  logic [15:0]         amplitude,
   input  logic [1:0]          sample_format,
   output logic [31:0]         sample
);
   import dmtg_pkg::*;

   logic signed [47:0] prod_ff;
   logic [31:0]        sample_ff;

   logic signed [32:0] a_s;
   logic signed [32:0] b_s;
   logic signed [32:0] w;
   logic [15:0]        amp_sat;
   logic signed [49:0] prod_full;
   logic               neg;
   logic [47:0]        mag;
   logic [33:0]        mag_r;
   logic [33:0]        hi;
   logic signed [33:0] res;
   logic [31:0]        sample_in;

   // Assemble the wave and scale it by the clamped gain
   always_comb begin
      a_s = front_q.neg_a ? -$signed({2'b00, rom_a}) : $signed({2'b00, rom_a});
      b_s = front_q.neg_b ? -$signed({2'b00, rom_b}) : $signed({2'b00, rom_b});
      case (front_q.wave)
         WAVE_SINE: w = $signed({a_s[31:0], 1'b0});
         WAVE_DTMF: w = a_s + b_s;
         default:   w = front_q.w_direct;
      endcase
      amp_sat   = (amplitude > AMP_FULL) ? AMP_FULL : amplitude;
      prod_full = w * $signed({1'b0, amp_sat});
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_full[47:0];
      end
   end

   // Round the magnitude half away from zero, restore sign, saturate, offset U8
   always_comb begin
      neg = prod_ff[47];
      mag = neg ? 48'(-prod_ff) : 48'(prod_ff);
      case (sample_format)
         FMT_U8: begin
            mag_r = 34'((mag + (48'd1 << 38)) >> 39);
            hi    = 34'd127;
         end
         FMT_S16: begin
            mag_r = 34'((mag + (48'd1 << 30)) >> 31);
            hi    = 34'd32767;
         end
         FMT_S24: begin
            mag_r = 34'((mag + (48'd1 << 22)) >> 23);
            hi    = 34'd8388607;
         end
         default: begin
            mag_r = 34'((mag + (48'd1 << 14)) >> 15);
            hi    = 34'd2147483647;
         end
      endcase
      if (!neg) begin
         res = (mag_r > hi) ? $signed(hi) : $signed(mag_r);
      end else if (mag_r > hi + 34'd1) begin
         res = -$signed(hi + 34'd1);
      end else begin
         res = -$signed(mag_r);
      end
      if (sample_format == FMT_U8) begin
         res = res + 34'sd128;
      end
      sample_in = res[31:0];
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

FILE: sv/dds_multiwave_tone_generator.sv
// Top level: control registers, stage handshakes and the three-stage sample path.
// An accepted tick passes the first stage, the multiply stage and the output register to rsp_tvalid.
// Throughput: one tick accepted per cycle unless the output stalls; stages collapse bubbles on a stall.
// The sine table read ports are registered, which sets the first stage.
// Reset (synchronous): phases cleared, noise LFSR seeded to 1, registers to
// defaults, pipeline emptied; the sine table is constant and needs no clearing.
module dds_multiwave_tone_generator #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart_phase, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sample
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dmtg_pkg::*;

   logic [2:0]  wave_type_ff;
   logic [31:0] tone_step_ff;
   logic [31:0] phase_offset_ff;
   logic [15:0] amplitude_ff;
   logic [31:0] col_step_ff;
   logic [31:0] row_step_ff;
   logic [1:0]  format_ff;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic out_valid_ff;
   logic s1_ready;
   logic s2_ready;
   logic out_ready;
   logic accept;

   logic [SINE_TABLE_BITS:0] addr_a;
   logic [SINE_TABLE_BITS:0] addr_b;
   logic [30:0]              rom_a;
   logic [30:0]              rom_b;
   front_type                front_q;

   // Register writes; always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_type_ff    <= WAVE_SINE;
         tone_step_ff    <= 32'd42852281;
         phase_offset_ff <= 32'd0;
         amplitude_ff    <= 16'd16384;
         col_step_ff     <= 32'd130185938;
         row_step_ff     <= 32'd91697396;
         format_ff       <= FMT_S16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WAVE_TYPE:     wave_type_ff    <= csr_data[2:0];
            REG_TONE_STEP:     tone_step_ff    <= csr_data;
            REG_PHASE_OFFSET:  phase_offset_ff <= csr_data;
            REG_AMPLITUDE:     amplitude_ff    <= csr_data[15:0];
            REG_DTMF_COL_STEP: col_step_ff     <= csr_data;
            REG_DTMF_ROW_STEP: row_step_ff     <= csr_data;
            REG_SAMPLE_FORMAT: format_ff       <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Stage handshakes: a stage loads when it is empty or its item moves on
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   dmtg_front #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .load_en       (s1_ready),
      .accept        (accept),
      .restart_phase (req_tdata[0]),
      .wave_type     (wave_type_ff),
      .tone_step     (tone_step_ff),
      .phase_offset  (phase_offset_ff),
      .dtmf_col_step (col_step_ff),
      .dtmf_row_step (row_step_ff),
      .addr_a        (addr_a),
      .addr_b        (addr_b),
      .front_q       (front_q)
   );

   dmtg_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .read_en (s1_ready),
      .addr_a  (addr_a),
      .addr_b  (addr_b),
      .data_a  (rom_a),
      .data_b  (rom_b)
   );

   dmtg_scale u_scale (
      .clock         (clock),
      .mul_en        (s2_ready),
      .out_en        (out_ready),
      .front_q       (front_q),
      .rom_a         (rom_a),
      .rom_b         (rom_b),
      .amplitude     (amplitude_ff),
      .sample_format (format_ff),
      .sample        (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // An accepted item occupies the first stage in the next cycle
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item missing from first stage");

   // A full, stalled pipeline takes no new item
   a_full_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && s2_valid_ff && s1_valid_ff) |-> !req_tready)
      else $error("input taken while every stage is held");

   // A held middle stage keeps its item
   a_s2_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_ready) |=> s2_valid_ff)
      else $error("stalled item dropped from multiply stage");
`endif

endmodule
